// ----- hw/rtl/smac_pkg.sv -----
// Shared types and constants of the shadow memory access checker.
// Used by smac_front, smac_fifo, smac_back and the top level; no dependencies.
package smac_pkg;

  localparam int GRANULE_SHIFT  = 3;
  localparam int GRANULE_BYTES  = 1 << GRANULE_SHIFT;
  localparam int SHADOW_ENTRIES = 4096;
  localparam int MAX_BYTES      = 4096;

  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 13;
  localparam int CODE_W   = 8;
  localparam int OP_W     = 2;
  localparam int IDX_W    = $clog2(SHADOW_ENTRIES);
  localparam int GRAN_W   = ADDR_W - GRANULE_SHIFT;
  localparam int CNT_W    = LEN_W - GRANULE_SHIFT;
  localparam int SUM_W    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [1:0] KIND_RESULT = 2'd0;
  localparam logic [1:0] KIND_CHECK  = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  typedef struct packed {
    logic                      enable;
    logic [ADDR_W-1:0]         base;
    logic [ADDR_W-1:0]         limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic                      ok;
    logic                      done;
    logic                      err;
    logic [IDX_W-1:0]          idx;
    logic [GRANULE_SHIFT-1:0]  off;
    logic [LEN_W-1:0]          rem;
    logic [IDX_W:0]            lim;
    logic [CNT_W-1:0]          cnt;
    logic [CNT_W-1:0]          whole;
    logic [GRANULE_SHIFT-1:0]  part;
    logic [CODE_W-1:0]         code;
  } desc_t;

endpackage

// ----- hw/rtl/smac_front.sv -----
// Front end: input register, window/index arithmetic and transaction classification.
// Depends on smac_pkg; feeds descriptors into smac_fifo.
module smac_front import smac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              clearing,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [ADDR_W-1:0] address,
  input  logic [LEN_W-1:0]  length,
  input  logic [LEN_W-1:0]  total_length,
  input  logic [CODE_W-1:0] shadow_code,
  output logic              push,
  output desc_t             push_data,
  input  logic              full
);

  localparam logic [LEN_W:0] RND_MASK = (LEN_W+1)'(GRANULE_BYTES - 1);

  logic              s_valid;
  logic [OP_W-1:0]   s_op;
  logic [ADDR_W-1:0] s_addr;
  logic [LEN_W-1:0]  s_len;
  logic [LEN_W-1:0]  s_total;
  logic [CODE_W-1:0] s_code;

  logic [GRAN_W:0]   d;
  logic              small_idx;
  logic              at_end;
  logic              cap;
  logic [IDX_W:0]    lim;
  logic              in_window;
  logic [LEN_W:0]    rounded;
  logic [CNT_W-1:0]  n_fill;
  logic [CNT_W-1:0]  n_total;
  logic              addr_mis;

  assign in_ready = !clearing && (!s_valid || !full);
  assign push     = s_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (push) begin
      s_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s_op    <= operation;
      s_addr  <= address;
      s_len   <= length;
      s_total <= total_length;
      s_code  <= shadow_code;
    end
  end

  function automatic logic fits(input logic [CNT_W-1:0] n, input logic sm,
                                input logic ae, input logic [IDX_W-1:0] idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(n);
    if (sm) begin
      return sum <= SUM_W'(SHADOW_ENTRIES);
    end
    return ae && (n == '0);
  endfunction

  assign d = {1'b0, s_addr[ADDR_W-1:GRANULE_SHIFT]}
           - {1'b0, cfg.base[ADDR_W-1:GRANULE_SHIFT]};
  assign small_idx = (d[GRAN_W:IDX_W] == '0);
  assign at_end    = (d == (GRAN_W+1)'(SHADOW_ENTRIES));
  // store top clipped where the granule space ends
  assign cap = &cfg.base[ADDR_W-1:GRANULE_SHIFT+IDX_W];
  assign lim = cap ? ({1'b0, ~cfg.base[GRANULE_SHIFT+IDX_W-1:GRANULE_SHIFT]} + 1'b1)
                   : (IDX_W+1)'(SHADOW_ENTRIES);
  assign in_window = (s_addr >= cfg.base) && (s_addr < cfg.limit);
  assign rounded   = ({1'b0, s_len} + RND_MASK) & ~RND_MASK;
  assign n_fill    = s_len[LEN_W-1:GRANULE_SHIFT];
  assign n_total   = s_total[LEN_W-1:GRANULE_SHIFT];
  assign addr_mis  = (s_addr[GRANULE_SHIFT-1:0] != '0);

  always_comb begin
    push_data       = '0;
    push_data.kind  = KIND_RESULT;
    push_data.ok    = 1'b1;
    push_data.idx   = d[IDX_W-1:0];
    push_data.off   = s_addr[GRANULE_SHIFT-1:0];
    push_data.rem   = s_len;
    push_data.lim   = lim;
    push_data.code  = s_code;
    if (cfg.enable) begin
      unique case (s_op)
        OP_CHECK: begin
          if (s_len == '0 || !in_window) begin
            push_data.kind = KIND_RESULT;
          end else if (s_len > LEN_W'(MAX_BYTES)) begin
            push_data.err = 1'b1;
          end else if (!small_idx) begin
            push_data.ok   = 1'b0;
            push_data.done = 1'b1;
            push_data.err  = 1'b1;
          end else begin
            push_data.kind = KIND_CHECK;
          end
        end
        OP_FILL: begin
          if (addr_mis || s_len[GRANULE_SHIFT-1:0] != '0 ||
              s_len > LEN_W'(MAX_BYTES) ||
              !fits(n_fill, small_idx, at_end, d[IDX_W-1:0])) begin
            push_data.err = 1'b1;
          end else begin
            push_data.kind = KIND_WRITE;
            push_data.done = 1'b1;
            push_data.cnt  = n_fill;
          end
        end
        OP_MARK: begin
          if (addr_mis || s_total[GRANULE_SHIFT-1:0] != '0 ||
              s_total > LEN_W'(MAX_BYTES) || rounded > {1'b0, s_total} ||
              !fits(n_total, small_idx, at_end, d[IDX_W-1:0])) begin
            push_data.err = 1'b1;
          end else begin
            push_data.kind  = KIND_WRITE;
            push_data.done  = 1'b1;
            push_data.cnt   = n_total;
            push_data.whole = s_len[LEN_W-1:GRANULE_SHIFT];
            push_data.part  = s_len[GRANULE_SHIFT-1:0];
          end
        end
        default: begin
          push_data.kind = KIND_RESULT;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/smac_fifo.sv -----
// Descriptor queue between the front end and the back end.
// Depends on smac_pkg.
module smac_fifo import smac_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/smac_back.sv -----
// Back end: shadow store, clearing sweep, granule walk for checks, region writes
// and the result register. Depends on smac_pkg; fed by smac_fifo.
module smac_back import smac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  desc_t             head,
  input  logic              empty,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              access_ok,
  output logic [CODE_W-1:0] bad_shadow,
  output logic              checked,
  output logic              error_flag
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;
  localparam logic [GRANULE_SHIFT-1:0] LAST_OFF = GRANULE_SHIFT'(GRANULE_BYTES - 1);

  logic [CODE_W-1:0] mem [SHADOW_ENTRIES];
  logic [CODE_W-1:0] rdata;
  logic              we;
  logic              re;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [CODE_W-1:0] wdata;

  logic [1:0]                state;
  logic [IDX_W-1:0]          clr_addr;
  logic [IDX_W:0]            cidx;
  logic [GRANULE_SHIFT-1:0]  off;
  logic [LEN_W-1:0]          rem;
  logic [IDX_W:0]            lim;
  logic [IDX_W-1:0]          widx;
  logic [CNT_W-1:0]          k;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          whole;
  logic [GRANULE_SHIFT-1:0]  part;
  logic [CODE_W-1:0]         code;

  logic                      out_free;
  logic                      out_load;
  logic [LEN_W:0]            span;
  logic                      span_gt;
  logic [GRANULE_SHIFT-1:0]  last_off;
  logic [CODE_W:0]           need;
  logic                      fail;
  logic [GRANULE_SHIFT:0]    consumed;
  logic [LEN_W-1:0]          rem_next;
  logic [IDX_W:0]            nidx;
  logic                      beyond;
  logic                      chk_final;

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || out_ready;

  // one granule per cycle: bytes off..last_off of the current granule
  assign span      = {1'b0, rem} + (LEN_W+1)'(off) - 1'b1;
  assign span_gt   = span > (LEN_W+1)'(LAST_OFF);
  assign last_off  = span_gt ? LAST_OFF : span[GRANULE_SHIFT-1:0];
  assign need      = (CODE_W+1)'(last_off) + 1'b1;
  assign fail      = (rdata != '0) && ($signed(need) > $signed({rdata[CODE_W-1], rdata}));
  assign consumed  = {1'b0, last_off} - {1'b0, off} + 1'b1;
  assign rem_next  = rem - LEN_W'(consumed);
  assign nidx      = cidx + 1'b1;
  assign beyond    = nidx >= lim;
  assign chk_final = fail || !span_gt || beyond;

  assign pop = (state == ST_IDLE) && !empty && ((head.kind != KIND_RESULT) || out_free);

  assign out_load = (pop && (head.kind == KIND_RESULT)) ||
                    ((state == ST_CHECK) && chk_final && out_free) ||
                    ((state == ST_WRITE) && (k == cnt) && out_free);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    raddr = head.idx;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        re = pop && (head.kind == KIND_CHECK);
      end
      ST_CHECK: begin
        re    = !chk_final;
        raddr = nidx[IDX_W-1:0];
      end
      ST_WRITE: begin
        we    = (k != cnt);
        waddr = widx;
        if (k < whole) begin
          wdata = '0;
        end else if (k == whole && part != '0) begin
          wdata = CODE_W'(part);
        end else begin
          wdata = code;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              KIND_CHECK: begin
                cidx  <= {1'b0, head.idx};
                off   <= head.off;
                rem   <= head.rem;
                lim   <= head.lim;
                state <= ST_CHECK;
              end
              KIND_WRITE: begin
                widx  <= head.idx;
                k     <= '0;
                cnt   <= head.cnt;
                whole <= head.whole;
                part  <= head.part;
                code  <= head.code;
                state <= ST_WRITE;
              end
              default: begin
                access_ok  <= head.ok;
                bad_shadow <= '0;
                checked    <= head.done;
                error_flag <= head.err;
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (!chk_final) begin
            cidx <= nidx;
            off  <= '0;
            rem  <= rem_next;
          end else if (out_free) begin
            checked   <= 1'b1;
            state     <= ST_IDLE;
            if (fail) begin
              access_ok  <= 1'b0;
              bad_shadow <= rdata;
              error_flag <= 1'b0;
            end else if (!span_gt) begin
              access_ok  <= 1'b1;
              bad_shadow <= '0;
              error_flag <= 1'b0;
            end else begin
              access_ok  <= 1'b0;
              bad_shadow <= '0;
              error_flag <= 1'b1;
            end
          end
        end
        ST_WRITE: begin
          if (k != cnt) begin
            widx <= widx + 1'b1;
            k    <= k + 1'b1;
          end else if (out_free) begin
            access_ok  <= 1'b1;
            bad_shadow <= '0;
            checked    <= 1'b1;
            error_flag <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/shadow_memory_access_checker_core.sv -----
// Top level of the shadow memory access checker: configuration registers,
// front end, descriptor queue and back end. Depends on smac_pkg and its modules.
//
// Usage: an input transaction (operation, address, length, total_length,
// shadow_code) is taken on in_valid & in_ready; one result transaction
// (access_ok, bad_shadow, checked, error_flag) leaves on out_valid & out_ready,
// in input order. Registers enable, window_base, window_limit are written
// through cfg_write / cfg_index / cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce it.
// Throughput is set by the back end, which handles one transaction at a time:
// a check reads one granule per cycle, a fill or mark writes one shadow entry
// per cycle, and a skipped or rejected transaction goes straight to the result
// register. After reset every shadow store entry is swept to zero; in_ready
// stays low during the sweep. A stalled receiver holds the result register;
// the front end and a 4-entry queue keep taking transactions until the queue
// and the input register are full.
module shadow_memory_access_checker_core import smac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       operation,
  input  logic [ADDR_W-1:0]     address,
  input  logic [LEN_W-1:0]      length,
  input  logic [LEN_W-1:0]      total_length,
  input  logic [CODE_W-1:0]     shadow_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  access_ok,
  output logic [CODE_W-1:0]     bad_shadow,
  output logic                  checked,
  output logic                  error_flag
);

  cfg_t  cfg;
  logic  clearing;
  logic  push;
  desc_t push_data;
  logic  full;
  logic  pop;
  desc_t head;
  logic  empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE: cfg.enable <= cfg_data[0];
        REG_BASE:   cfg.base   <= cfg_data;
        REG_LIMIT:  cfg.limit  <= cfg_data;
        default:    cfg        <= cfg;
      endcase
    end
  end

  smac_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .clearing     (clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .address      (address),
    .length       (length),
    .total_length (total_length),
    .shadow_code  (shadow_code),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  smac_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  smac_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .access_ok  (access_ok),
    .bad_shadow (bad_shadow),
    .checked    (checked),
    .error_flag (error_flag)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("transaction accepted during store sweep");

  a_bad_shadow_means_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_shadow != '0 |-> !access_ok && checked && !error_flag)
    else $error("bad_shadow reported without a failed check");

  a_skipped_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checked |-> access_ok && bad_shadow == '0)
    else $error("skipped transaction reports a violation");

  a_overrun_fails: assert property (@(posedge clk) disable iff (rst)
    out_valid && checked && error_flag |-> !access_ok && bad_shadow == '0)
    else $error("store overrun not reported as failure");

endmodule
